// ===== rtl/stt_pkg.sv =====
// Shared constants, item types and microcode encodings for the sorted time table.
package stt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int TIME_W      = 32;
	localparam int STEP_W      = 4;

	// action codes
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// datapath operations
	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_ACCEPT  = 4'd1;
	localparam logic [3:0] OP_RD0     = 4'd2;
	localparam logic [3:0] OP_RD1     = 4'd3;
	localparam logic [3:0] OP_DIR     = 4'd4;
	localparam logic [3:0] OP_PROBE   = 4'd5;
	localparam logic [3:0] OP_STEP    = 4'd6;
	localparam logic [3:0] OP_BRACKET = 4'd7;
	localparam logic [3:0] OP_RDHI    = 4'd8;
	localparam logic [3:0] OP_NEAR    = 4'd9;
	localparam logic [3:0] OP_SMALL   = 4'd10;
	localparam logic [3:0] OP_MODIFY  = 4'd11;
	localparam logic [3:0] OP_EMIT    = 4'd12;

	// jump conditions
	localparam logic [2:0] C_NEVER      = 3'd0;
	localparam logic [2:0] C_ALWAYS     = 3'd1;
	localparam logic [2:0] C_NO_INPUT   = 3'd2;
	localparam logic [2:0] C_NOT_LOOKUP = 3'd3;
	localparam logic [2:0] C_N_LE1      = 3'd4;
	localparam logic [2:0] C_SPAN_ZERO  = 3'd5;
	localparam logic [2:0] C_OUT_FREE   = 3'd6;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [TIME_W-1:0] time_value;
	} stt_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] lower_index;
		logic [IDX_W-1:0] upper_index;
		logic [IDX_W-1:0] nearest_index;
		logic [CNT_W-1:0] entry_count;
		logic [1:0]       status;
	} stt_out_t;

	typedef struct packed {
		logic [3:0]        op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} stt_uword_t;

	typedef struct packed {
		logic in_valid;
		logic not_lookup;
		logic n_le1;
		logic span_zero;
		logic out_free;
	} stt_flags_t;

endpackage

// ===== rtl/sorted_time_table_nearest_lookup.sv =====
// Top level: sorted time table with lower-bound nearest lookup, microcoded.
// A lookup on n >= 2 entries runs a binary search of at most floor(log2 n) + 1 probes; a
// probe is a memory read plus a compare. Append, clear, unused actions and lookups on 0
// or 1 entries take no probes. One item in work at a time, the next taken while the
// previous result waits; a stalled result holds the emit step. Reset clears count and
// flags, not the table.
module sorted_time_table_nearest_lookup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic              cfg_write_data,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  stt_pkg::stt_in_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output stt_pkg::stt_out_t rsp
);
	import stt_pkg::*;

	stt_uword_t uword;
	stt_flags_t flags;
	stt_out_t   result;
	logic       rsp_valid_q;
	stt_out_t   rsp_q;
	logic       out_free;
	logic       load;

	// The result register frees up when empty or when its item is taken this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Take a command only while the sequencer sits in its wait step.
	assign cmd_stall = uword.op != OP_ACCEPT;

	// Load the result register on the emit step once it is free.
	assign load = (uword.op == OP_EMIT) && out_free;

	stt_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uword  (uword)
	);

	stt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.uword          (uword),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.out_free       (out_free),
		.flags          (flags),
		.result         (result)
	);

	// Hold the result until taken; drop valid once the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// One item in work at a time: an accept is never followed by another at once.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command accepted on two consecutive cycles");

	// An emit into a free result register always shows up as a valid result.
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rsp_valid)
		else $error("emitted result did not reach the output");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_count <= CNT_W'(TABLE_DEPTH)))
		else $error("entry count beyond table depth");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_EMPTY ||
			rsp.status == ST_FULL))
		else $error("undefined status code");

	// The nearest entry is one of the bracketing pair, which is ordered.
	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_OK) |->
		(rsp.lower_index <= rsp.upper_index &&
			(rsp.nearest_index == rsp.lower_index ||
			rsp.nearest_index == rsp.upper_index)))
		else $error("nearest index outside the bracketing pair");

endmodule

// ===== rtl/stt_useq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module stt_useq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stt_pkg::stt_flags_t    flags,
	output stt_pkg::stt_uword_t    uword
);
	import stt_pkg::*;

	localparam logic [STEP_W-1:0] S_WAIT    = 4'd0;
	localparam logic [STEP_W-1:0] S_DECODE  = 4'd1;
	localparam logic [STEP_W-1:0] S_SIZE    = 4'd2;
	localparam logic [STEP_W-1:0] S_RD0     = 4'd3;
	localparam logic [STEP_W-1:0] S_RD1     = 4'd4;
	localparam logic [STEP_W-1:0] S_DIR     = 4'd5;
	localparam logic [STEP_W-1:0] S_PROBE   = 4'd6;
	localparam logic [STEP_W-1:0] S_STEP    = 4'd7;
	localparam logic [STEP_W-1:0] S_BRACKET = 4'd8;
	localparam logic [STEP_W-1:0] S_RDHI    = 4'd9;
	localparam logic [STEP_W-1:0] S_NEAR    = 4'd10;
	localparam logic [STEP_W-1:0] S_SMALL   = 4'd11;
	localparam logic [STEP_W-1:0] S_MODIFY  = 4'd12;
	localparam logic [STEP_W-1:0] S_EMIT    = 4'd13;
	localparam logic [STEP_W-1:0] S_HOLD    = 4'd14;

	// jump to target when the condition holds, else fall through
	function automatic stt_uword_t ucode_rom(input logic [STEP_W-1:0] addr);
		stt_uword_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
		case (addr)
			S_WAIT:    w = '{op: OP_ACCEPT,  cond: C_NO_INPUT,   target: S_WAIT};
			S_DECODE:  w = '{op: OP_NOP,     cond: C_NOT_LOOKUP, target: S_MODIFY};
			S_SIZE:    w = '{op: OP_NOP,     cond: C_N_LE1,      target: S_SMALL};
			S_RD0:     w = '{op: OP_RD0,     cond: C_NEVER,      target: S_WAIT};
			S_RD1:     w = '{op: OP_RD1,     cond: C_NEVER,      target: S_WAIT};
			S_DIR:     w = '{op: OP_DIR,     cond: C_NEVER,      target: S_WAIT};
			S_PROBE:   w = '{op: OP_PROBE,   cond: C_SPAN_ZERO,  target: S_BRACKET};
			S_STEP:    w = '{op: OP_STEP,    cond: C_ALWAYS,     target: S_PROBE};
			S_BRACKET: w = '{op: OP_BRACKET, cond: C_NEVER,      target: S_WAIT};
			S_RDHI:    w = '{op: OP_RDHI,    cond: C_NEVER,      target: S_WAIT};
			S_NEAR:    w = '{op: OP_NEAR,    cond: C_ALWAYS,     target: S_EMIT};
			S_SMALL:   w = '{op: OP_SMALL,   cond: C_ALWAYS,     target: S_EMIT};
			S_MODIFY:  w = '{op: OP_MODIFY,  cond: C_NEVER,      target: S_WAIT};
			S_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT_FREE,   target: S_WAIT};
			S_HOLD:    w = '{op: OP_NOP,     cond: C_ALWAYS,     target: S_EMIT};
			default:   w = '{op: OP_NOP,     cond: C_ALWAYS,     target: S_WAIT};
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic              taken;

	assign uword = ucode_rom(step_q);

	always_comb begin
		case (uword.cond)
			C_NEVER:      taken = 1'b0;
			C_ALWAYS:     taken = 1'b1;
			C_NO_INPUT:   taken = !flags.in_valid;
			C_NOT_LOOKUP: taken = flags.not_lookup;
			C_N_LE1:      taken = flags.n_le1;
			C_SPAN_ZERO:  taken = flags.span_zero;
			C_OUT_FREE:   taken = flags.out_free;
			default:      taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else if (taken) begin
			step_q <= uword.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ===== rtl/stt_dpath.sv =====
// Datapath: timestamp memory, search registers, distance compare and table count.
module stt_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic                cfg_write_data,
	input  stt_pkg::stt_uword_t uword,
	input  logic                cmd_valid,
	input  stt_pkg::stt_in_t    cmd,
	input  logic                out_free,
	output stt_pkg::stt_flags_t flags,
	output stt_pkg::stt_out_t   result
);
	import stt_pkg::*;

	logic signed [TIME_W-1:0] mem [TABLE_DEPTH];
	logic signed [TIME_W-1:0] rdata_q;
	logic [IDX_W-1:0]         raddr;
	logic [IDX_W-1:0]         waddr;
	logic                     mem_we;

	logic [CNT_W-1:0]         count_q;
	logic                     cleared_q;
	logic                     cow_q;

	logic [1:0]               action_q;
	logic signed [TIME_W-1:0] key_q;
	logic signed [TIME_W-1:0] t0_q;
	logic                     desc_q;
	logic [CNT_W-1:0]         first_q;
	logic [CNT_W-1:0]         span_q;
	logic [IDX_W-1:0]         lo_q;
	logic [IDX_W-1:0]         hi_q;
	logic [IDX_W-1:0]         near_q;
	logic [1:0]               status_q;
	logic [TIME_W:0]          dlo_q;

	logic [CNT_W-1:0]         half;
	logic [CNT_W-1:0]         probe;
	logic                     precedes;
	logic [IDX_W-1:0]         br_lo;
	logic [IDX_W-1:0]         br_hi;
	logic signed [TIME_W:0]   d_kr;
	logic signed [TIME_W:0]   d_rk;
	logic [TIME_W:0]          key_gap;
	logic                     wipe;
	logic [CNT_W-1:0]         base;
	logic                     full;
	logic [CNT_W-1:0]         last;

	// search window arithmetic
	assign half     = span_q >> 1;
	assign probe    = first_q + half;
	assign precedes = desc_q ? (rdata_q > key_q) : (rdata_q < key_q);
	assign last     = count_q - 1'b1;

	always_comb begin
		if (first_q == '0) begin
			br_lo = '0;
			br_hi = '0;
		end else if (first_q >= count_q) begin
			br_lo = last[IDX_W-1:0];
			br_hi = last[IDX_W-1:0];
		end else begin
			br_lo = first_q[IDX_W-1:0] - 1'b1;
			br_hi = first_q[IDX_W-1:0];
		end
	end

	// distance from key to the entry just read, both differences in parallel
	assign d_kr    = {key_q[TIME_W-1], key_q} - {rdata_q[TIME_W-1], rdata_q};
	assign d_rk    = {rdata_q[TIME_W-1], rdata_q} - {key_q[TIME_W-1], key_q};
	assign key_gap = d_kr[TIME_W] ? d_rk : d_kr;

	// append: empty first on clear-on-write, drop when full
	assign wipe   = !cleared_q && cow_q;
	assign base   = wipe ? '0 : count_q;
	assign full   = base >= CNT_W'(TABLE_DEPTH);
	assign waddr  = base[IDX_W-1:0];
	assign mem_we = (uword.op == OP_MODIFY) && (action_q == ACT_APPEND) && !full;

	always_comb begin
		case (uword.op)
			OP_RD0:     raddr = '0;
			OP_RD1:     raddr = IDX_W'(1);
			OP_PROBE:   raddr = probe[IDX_W-1:0];
			OP_BRACKET: raddr = br_lo;
			OP_RDHI:    raddr = hi_q;
			default:    raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= key_q;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cleared_q <= 1'b0;
			cow_q     <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				cow_q <= cfg_write_data;
			end
			if (uword.op == OP_MODIFY) begin
				case (action_q)
					ACT_APPEND: begin
						if (wipe) begin
							cleared_q <= 1'b1;
						end
						count_q <= full ? base : base + 1'b1;
					end
					ACT_CLEAR: begin
						count_q   <= '0;
						cleared_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uword.op)
			OP_ACCEPT: begin
				if (cmd_valid) begin
					action_q <= cmd.action;
					key_q    <= cmd.time_value;
					lo_q     <= '0;
					hi_q     <= '0;
					near_q   <= '0;
					status_q <= ST_OK;
				end
			end
			OP_RD1: t0_q <= rdata_q;
			OP_DIR: begin
				desc_q  <= t0_q > rdata_q;
				first_q <= '0;
				span_q  <= count_q;
			end
			OP_STEP: begin
				if (precedes) begin
					first_q <= probe + 1'b1;
					span_q  <= span_q - half - 1'b1;
				end else begin
					span_q <= half;
				end
			end
			OP_BRACKET: begin
				lo_q <= br_lo;
				hi_q <= br_hi;
			end
			OP_RDHI: dlo_q <= key_gap;
			OP_NEAR: near_q <= (dlo_q < key_gap) ? lo_q : hi_q;
			OP_SMALL: status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
			OP_MODIFY: status_q <= ((action_q == ACT_APPEND) && full) ? ST_FULL : ST_OK;
			default: ;
		endcase
	end

	assign flags.in_valid   = cmd_valid;
	assign flags.not_lookup = action_q != ACT_LOOKUP;
	assign flags.n_le1      = count_q <= CNT_W'(1);
	assign flags.span_zero  = span_q == '0;
	assign flags.out_free   = out_free;

	assign result.lower_index   = lo_q;
	assign result.upper_index   = hi_q;
	assign result.nearest_index = near_q;
	assign result.entry_count   = count_q;
	assign result.status        = status_q;

endmodule
